### hdl/pk2nv_pkg.sv
// Package: shared widths, register indexes, reset values and payload types.
`default_nettype none
package pk2nv_pkg;

   localparam int MAX_PAIRS_DEFAULT = 2048;
   localparam int HEIGHT_LIMIT      = 4096;

   localparam int PIXEL_W   = 8;
   localparam int WIDTH_W   = 12;
   localparam int HEIGHT_W  = 13;
   localparam int ROW_W     = 12;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 13;
   localparam int CHROMA_W  = 2 * PIXEL_W;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_ORDER       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH_PAIRS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT      = 2'd2;

   // pixel_order codes
   localparam logic ORDER_YUYV = 1'b0;
   localparam logic ORDER_UYVY = 1'b1;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd960;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd1080;

   // word between the input register and the result register
   typedef struct packed {
      logic [PIXEL_W-1:0] luma_first;
      logic [PIXEL_W-1:0] luma_second;
      logic [PIXEL_W-1:0] blue_diff;
      logic [PIXEL_W-1:0] red_diff;
      logic               odd_row;
      logic               end_of_frame;
   } stage_type;

endpackage
`default_nettype wire

### hdl/pk2nv_if.sv
// Interfaces: request, response and register write channels.
`default_nettype none
interface pk2nv_req_if;
   logic                          valid;
   logic                          ready;
   logic [pk2nv_pkg::PIXEL_W-1:0] byte_a;
   logic [pk2nv_pkg::PIXEL_W-1:0] byte_b;
   logic [pk2nv_pkg::PIXEL_W-1:0] byte_c;
   logic [pk2nv_pkg::PIXEL_W-1:0] byte_d;
   logic                          start_of_frame;

   modport source (output valid, byte_a, byte_b, byte_c, byte_d, start_of_frame,
                   input ready);
   modport sink   (input valid, byte_a, byte_b, byte_c, byte_d, start_of_frame,
                   output ready);
endinterface

interface pk2nv_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [pk2nv_pkg::PIXEL_W-1:0] luma_first;
   logic [pk2nv_pkg::PIXEL_W-1:0] luma_second;
   logic                          chroma_valid;
   logic [pk2nv_pkg::PIXEL_W-1:0] blue_diff;
   logic [pk2nv_pkg::PIXEL_W-1:0] red_diff;
   logic                          end_of_frame;

   modport source (output valid, luma_first, luma_second, chroma_valid, blue_diff,
                   red_diff, end_of_frame, input ready);
   modport sink   (input valid, luma_first, luma_second, chroma_valid, blue_diff,
                   red_diff, end_of_frame, output ready);
endinterface

interface pk2nv_csr_if;
   logic                            valid;
   logic                            ready;
   logic [pk2nv_pkg::CSR_IDX_W-1:0] index;
   logic [pk2nv_pkg::CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hdl/packed_422_to_nv12_converter_core.sv
// Top level: packed 4:2:2 pixel pair stream to NV12 luma words and averaged chroma.
// ---------------------------------------------------------------------------------
// Usage
//   req_bus : one packed pixel pair per word (byte_a..byte_d, start_of_frame).
//             Byte order is set by pixel_order (YUYV or UYVY).
//   rsp_bus : one word per request word: two luma bytes, and on odd rows the
//             Cb/Cr pair averaged with the one stored from the row above.
//   csr_bus : register writes (0 pixel_order, 1 frame_width_pairs,
//             2 frame_height); always ready, write only while idle.
// Throughput: one word per cycle, sustained while rsp_bus.ready stays high.
// Path: from request accept to response valid a word passes the line
//   buffer's registered read port (stage 1) and the result register (stage 2).
// Reset: row/column counters zero, registers to defaults, both stages empty.
//   The line buffer is not cleared; odd rows read what even rows stored.
// Stall: while rsp_bus.ready is low the result word holds; the pipeline
//   takes one more word into stage 1 if it is empty, then req_bus.ready drops.
// ---------------------------------------------------------------------------------
`default_nettype none
module packed_422_to_nv12_converter_core #(
   parameter int MAX_PAIRS = pk2nv_pkg::MAX_PAIRS_DEFAULT
) (
   input wire logic     clock,
   input wire logic     reset,
   pk2nv_req_if.sink    req_bus,
   pk2nv_rsp_if.source  rsp_bus,
   pk2nv_csr_if.sink    csr_bus
);

   localparam int ADDR_W = $clog2(MAX_PAIRS);
   // compare width: holds the register value and MAX_PAIRS itself
   localparam int WW = ($clog2(MAX_PAIRS + 1) > pk2nv_pkg::WIDTH_W) ?
                       $clog2(MAX_PAIRS + 1) : pk2nv_pkg::WIDTH_W;
   localparam int PW = pk2nv_pkg::PIXEL_W;

   // ---------------- configuration registers ----------------
   logic                             pixel_order_ff;
   logic [pk2nv_pkg::WIDTH_W-1:0]    width_ff;
   logic [pk2nv_pkg::HEIGHT_W-1:0]   height_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_order_ff <= pk2nv_pkg::ORDER_YUYV;
         width_ff       <= pk2nv_pkg::WIDTH_RESET;
         height_ff      <= pk2nv_pkg::HEIGHT_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            pk2nv_pkg::CSR_PIXEL_ORDER:       pixel_order_ff <= csr_bus.data[0];
            pk2nv_pkg::CSR_FRAME_WIDTH_PAIRS:
               width_ff <= csr_bus.data[pk2nv_pkg::WIDTH_W-1:0];
            pk2nv_pkg::CSR_FRAME_HEIGHT:
               height_ff <= csr_bus.data[pk2nv_pkg::HEIGHT_W-1:0];
            default: ;  // unmapped index: ignored
         endcase
      end
   end

   // effective sizes: zero acts as one, oversize saturates
   logic [WW-1:0]                  eff_width;
   logic [pk2nv_pkg::HEIGHT_W-1:0] eff_height;

   always_comb begin
      if (width_ff == '0) begin
         eff_width = WW'(1);
      end else if (WW'(width_ff) > WW'(MAX_PAIRS)) begin
         eff_width = WW'(MAX_PAIRS);
      end else begin
         eff_width = WW'(width_ff);
      end
      if (height_ff == '0) begin
         eff_height = pk2nv_pkg::HEIGHT_W'(1);
      end else if (height_ff > pk2nv_pkg::HEIGHT_W'(pk2nv_pkg::HEIGHT_LIMIT)) begin
         eff_height = pk2nv_pkg::HEIGHT_W'(pk2nv_pkg::HEIGHT_LIMIT);
      end else begin
         eff_height = height_ff;
      end
   end

   // ---------------- handshake ----------------
   logic s1_valid_ff, s2_valid_ff;
   logic s2_load, s1_load, req_accept;

   assign s2_load       = s1_valid_ff & (~s2_valid_ff | rsp_bus.ready);
   assign req_bus.ready = ~s1_valid_ff | s2_load;
   assign req_accept    = req_bus.valid & req_bus.ready;
   assign s1_load       = req_accept;

   // ---------------- counters (at accept) ----------------
   logic [ADDR_W-1:0]             col_ff, col_in, col_cur;
   logic [pk2nv_pkg::ROW_W-1:0]   row_ff, row_in, row_cur;
   logic                          last_col, last_row;

   always_comb begin
      // start of frame zeroes both counters before use
      col_cur  = req_bus.start_of_frame ? '0 : col_ff;
      row_cur  = req_bus.start_of_frame ? '0 : row_ff;
      last_col = (WW'(col_cur) + WW'(1)) >= eff_width;
      last_row = ({1'b0, row_cur} + pk2nv_pkg::HEIGHT_W'(1)) >= eff_height;
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : row_cur + pk2nv_pkg::ROW_W'(1);
      end else begin
         col_in = col_cur + ADDR_W'(1);
         row_in = row_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------- unpack ----------------
   logic [PW-1:0] y0, y1, cb, cr;

   always_comb begin
      if (pixel_order_ff == pk2nv_pkg::ORDER_UYVY) begin
         cb = req_bus.byte_a;
         y0 = req_bus.byte_b;
         cr = req_bus.byte_c;
         y1 = req_bus.byte_d;
      end else begin
         y0 = req_bus.byte_a;
         cb = req_bus.byte_b;
         y1 = req_bus.byte_c;
         cr = req_bus.byte_d;
      end
   end

   // ---------------- line buffer ----------------
   // even rows write at accept; odd rows read at accept, data lands with stage 1
   logic                          odd_now;
   logic [pk2nv_pkg::CHROMA_W-1:0] upper;

   assign odd_now = row_cur[0];

   pk2nv_ram #(
      .WIDTH (pk2nv_pkg::CHROMA_W),
      .DEPTH (MAX_PAIRS)
   ) u_chroma_line (
      .clock   (clock),
      .wr_en   (req_accept & ~odd_now),
      .wr_addr (col_cur),
      .wr_data ({cr, cb}),
      .rd_en   (req_accept & odd_now),
      .rd_addr (col_cur),
      .rd_data (upper)
   );

   // ---------------- stage 1: input register ----------------
   pk2nv_pkg::stage_type s1_ff, s1_in;

   always_comb begin
      s1_in.luma_first   = y0;
      s1_in.luma_second  = y1;
      s1_in.blue_diff    = cb;
      s1_in.red_diff     = cr;
      s1_in.odd_row      = odd_now;
      s1_in.end_of_frame = last_col & last_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_load) begin
         s1_valid_ff <= 1'b1;
      end else if (s2_load) begin
         s1_valid_ff <= 1'b0;
      end
      if (s1_load) begin
         s1_ff <= s1_in;
      end
   end

   // ---------------- average, stage 2: result register ----------------
   logic [PW:0]   cb_sum, cr_sum;
   logic [PW-1:0] cb_out_in, cr_out_in;

   always_comb begin
      cb_sum = {1'b0, upper[PW-1:0]} + {1'b0, s1_ff.blue_diff};
      cr_sum = {1'b0, upper[2*PW-1:PW]} + {1'b0, s1_ff.red_diff};
      cb_out_in = s1_ff.odd_row ? cb_sum[PW:1] : '0;
      cr_out_in = s1_ff.odd_row ? cr_sum[PW:1] : '0;
   end

   logic [PW-1:0] luma_first_ff, luma_second_ff, blue_ff, red_ff;
   logic          chroma_valid_ff, eof_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_load) begin
         s2_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         s2_valid_ff <= 1'b0;
      end
      if (s2_load) begin
         luma_first_ff   <= s1_ff.luma_first;
         luma_second_ff  <= s1_ff.luma_second;
         chroma_valid_ff <= s1_ff.odd_row;
         blue_ff         <= cb_out_in;
         red_ff          <= cr_out_in;
         eof_ff          <= s1_ff.end_of_frame;
      end
   end

   assign rsp_bus.valid        = s2_valid_ff;
   assign rsp_bus.luma_first   = luma_first_ff;
   assign rsp_bus.luma_second  = luma_second_ff;
   assign rsp_bus.chroma_valid = chroma_valid_ff;
   assign rsp_bus.blue_diff    = blue_ff;
   assign rsp_bus.red_diff     = red_ff;
   assign rsp_bus.end_of_frame = eof_ff;

endmodule
`default_nettype wire

### hdl/pk2nv_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pk2nv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire
